FILE: rtl/ght_pkg.sv
// Package for the generational handle table: operation, status and state codes.
// Used by ght_ctrl, ght_datapath and generational_handle_table.
`timescale 1ns / 1ps
`default_nettype none
package ght_pkg;

  localparam int DefSlots   = 64;
  localparam int DefMaxSide = 4096;
  localparam logic [32:0] BudgetReset = 33'd67108864;
  localparam logic [15:0] CntMax = 16'hffff;

  typedef enum logic [3:0] {
    OP_CREATE  = 4'd0,
    OP_RETAIN  = 4'd1,
    OP_RELEASE = 4'd2,
    OP_PIN     = 4'd3,
    OP_UNPIN   = 4'd4,
    OP_BEGIN   = 4'd5,
    OP_END     = 4'd6,
    OP_TOUCH   = 4'd7,
    OP_LOOKUP  = 4'd8,
    OP_BUDGET  = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_ZERO    = 3'd2,
    ST_FULL    = 3'd3,
    ST_SAT     = 3'd4,
    ST_SIZE    = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_EXEC,
    S_SCAN,
    S_SUM,
    S_CHECK,
    S_MIN,
    S_EVICT,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic load;
    logic rd_handle;
    logic exec;
    logic scan_start;
    logic scan_step;
    logic sum_step;
    logic min_step;
    logic evict;
    logic finish;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_create;
    logic is_budget;
    logic immediate;
    logic scan_last;
    logic over_budget;
    logic have_best;
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/generational_handle_table.sv
// Top level of the generational handle table: controller plus datapath.
// Depends on ght_pkg, ght_ctrl and ght_datapath.
//
//  channel  | handshake               | word
//  input    | start / busy            | in_op, in_handle, in_width, in_height, in_keyed
//  result   | out_valid strobe        | out_status .. out_warm_bytes
//  config   | cfg_we                  | cfg_wdata (warm budget)
//
// Handle operations go from S_READ through S_EXEC to S_DONE, which raises the strobe;
// a bad handle index, bad size or unknown code goes from S_READ straight to S_DONE.
// Create scans the slot memory one entry a cycle.
// Budget update sums in one pass and then takes one full pass per eviction.
// After reset a clearing pass over every slot runs with busy high.
// Results cannot be stalled; each strobe lasts one cycle.
`timescale 1ns / 1ps
`default_nettype none
module generational_handle_table import ght_pkg::*; #(
  parameter int SLOTS    = DefSlots,
  parameter int MAX_SIDE = DefMaxSide
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [3:0]  in_op,
  input  wire  [31:0] in_handle,
  input  wire  [12:0] in_width,
  input  wire  [12:0] in_height,
  input  wire         in_keyed,
  input  wire         cfg_we,
  input  wire  [32:0] cfg_wdata,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [30:0] out_handle,
  output logic [12:0] out_width,
  output logic [12:0] out_height,
  output logic [15:0] out_ref_count,
  output logic        out_freed,
  output logic [6:0]  out_evicted_count,
  output logic [32:0] out_warm_bytes
);

  cmd_t  cmd;
  stat_t st;

  ght_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .st    (st)
  );

  ght_datapath #(.SLOTS(SLOTS), .MAX_SIDE(MAX_SIDE)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_op             (in_op),
    .in_handle         (in_handle),
    .in_width          (in_width),
    .in_height         (in_height),
    .in_keyed          (in_keyed),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_handle        (out_handle),
    .out_width         (out_width),
    .out_height        (out_height),
    .out_ref_count     (out_ref_count),
    .out_freed         (out_freed),
    .out_evicted_count (out_evicted_count),
    .out_warm_bytes    (out_warm_bytes)
  );

endmodule
`default_nettype wire

FILE: rtl/ght_ctrl.sv
// Controller state machine for the generational handle table.
// Depends on ght_pkg; drives ght_datapath through cmd_t and reads stat_t.
`timescale 1ns / 1ps
`default_nettype none
module ght_ctrl import ght_pkg::*; (
  input  wire   clk,
  input  wire   rst_n,
  input  wire   start,
  output logic  busy,
  output cmd_t  cmd,
  input  stat_t st
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (st.clr_last) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_READ;
      S_READ: begin
        if (st.immediate) state_nxt = S_DONE;
        else if (st.is_create || st.is_budget) state_nxt = S_SCAN;
        else state_nxt = S_EXEC;
      end
      S_EXEC:  state_nxt = S_DONE;
      S_SCAN: begin
        if (st.scan_last) state_nxt = st.is_create ? S_EXEC : S_CHECK;
      end
      S_SUM:   state_nxt = S_CHECK;
      S_CHECK: state_nxt = st.over_budget ? S_MIN : S_DONE;
      S_MIN: begin
        if (st.scan_last) state_nxt = S_EVICT;
      end
      S_EVICT: state_nxt = st.have_best ? S_CHECK : S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        busy = 1'b0;
        cmd.load = start;
      end
      S_READ:  begin
        cmd.rd_handle  = 1'b1;
        cmd.scan_start = 1'b1;
      end
      S_EXEC:  cmd.exec = 1'b1;
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.sum_step  = st.is_budget;
        cmd.scan_start = st.scan_last;
      end
      S_SUM:   cmd.scan_start = 1'b1;
      S_CHECK: cmd.scan_start = 1'b1;
      S_MIN:   begin
        cmd.scan_step = 1'b1;
        cmd.min_step  = 1'b1;
      end
      S_EVICT: begin
        cmd.evict = 1'b1;
        cmd.scan_start = 1'b1;
      end
      S_DONE:  cmd.finish = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/ght_datapath.sv
// Datapath of the generational handle table: slot store, scan counter,
// warm-byte accumulator, LRU search and result register. Depends on ght_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ght_datapath import ght_pkg::*; #(
  parameter int SLOTS    = DefSlots,
  parameter int MAX_SIDE = DefMaxSide
) (
  input  wire         clk,
  input  wire         rst_n,
  input  cmd_t        cmd,
  output stat_t       st,
  input  wire         cfg_we,
  input  wire  [32:0] cfg_wdata,
  input  wire  [3:0]  in_op,
  input  wire  [31:0] in_handle,
  input  wire  [12:0] in_width,
  input  wire  [12:0] in_height,
  input  wire         in_keyed,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [30:0] out_handle,
  output logic [12:0] out_width,
  output logic [12:0] out_height,
  output logic [15:0] out_ref_count,
  output logic        out_freed,
  output logic [6:0]  out_evicted_count,
  output logic [32:0] out_warm_bytes
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  // Slot record held in one memory word.
  typedef struct packed {
    logic        live;
    logic [14:0] gen;
    logic [12:0] w;
    logic [12:0] h;
    logic [15:0] refs;
    logic [15:0] pins;
    logic [15:0] infl;
    logic        keyed;
    logic [31:0] last;
  } slot_t;

  slot_t mem [SLOTS];
  slot_t rd_r;
  logic [IW-1:0] rd_addr;
  logic          we;
  logic [IW-1:0] wa;
  slot_t         wd;

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[rd_addr];
  end

  // Captured request and configuration.
  logic [3:0]  op_r;
  logic [31:0] hdl_r;
  logic [12:0] w_r, h_r;
  logic        key_r;
  logic [32:0] budget_r;
  logic [31:0] serial_r;
  logic [CW-1:0] clr_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] tgt_r;
  logic [14:0]   tgt_gen_r;
  logic          found_r;
  logic [33:0]   total_r;
  logic          best_v_r;
  logic [IW-1:0] best_r;
  logic [14:0]   best_gen_r;
  logic [31:0]   best_last_r;
  logic [25:0]   best_px_r;
  logic          cnt_v_r;
  logic [IW-1:0] cnt_idx_r;
  logic [6:0]    ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) budget_r <= BudgetReset;
    else if (cfg_we) budget_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_op;
      hdl_r <= in_handle;
      w_r   <= in_width;
      h_r   <= in_height;
      key_r <= in_keyed;
    end
  end

  // Decode of the captured request.
  logic [15:0] enc;
  logic        idx_ok;
  logic        size_bad;
  assign enc      = hdl_r[15:0];
  assign idx_ok   = !hdl_r[31] && enc != 16'd0 && ({16'd0, enc} <= 32'(SLOTS));
  assign size_bad = w_r == 13'd0 || h_r == 13'd0 ||
                    {19'd0, w_r} > 32'(MAX_SIDE) || {19'd0, h_r} > 32'(MAX_SIDE);
  logic [IW-1:0] hidx;
  assign hidx = IW'({16'd0, enc} - 32'd1);

  assign st.is_create = op_r == OP_CREATE;
  assign st.is_budget = op_r == OP_BUDGET;
  assign st.immediate = (op_r > OP_BUDGET) || (st.is_create && size_bad) ||
                        (!st.is_create && !st.is_budget && !idx_ok);
  assign st.clr_last  = clr_r == CW'(SLOTS - 1);
  assign st.scan_last = cnt_r == CW'(SLOTS);
  assign st.over_budget = total_r > {1'b0, budget_r};
  assign st.have_best = best_v_r;

  // Read address: handle slot for handle ops, target slot on create exec, else scan slot.
  always_comb begin
    if (cmd.rd_handle || (cmd.exec && !st.is_create)) rd_addr = hidx;
    else if (cmd.exec && st.is_create) rd_addr = tgt_r;
    else rd_addr = cnt_r[IW-1:0];
  end

  logic warm;
  assign warm = rd_r.live && rd_r.keyed && rd_r.refs == 16'd0 &&
                rd_r.pins == 16'd0 && rd_r.infl == 16'd0;

  // Handle operation evaluation on the registered slot word.
  slot_t    upd;
  logic     kill;
  logic     mark;
  status_t  hst;
  logic     hok;
  logic [14:0] ngen;
  always_comb begin
    upd  = rd_r;
    kill = 1'b0;
    mark = 1'b0;
    hst  = ST_OK;
    hok  = rd_r.live && rd_r.gen == hdl_r[30:16];
    case (op_r)
      OP_RETAIN: if (rd_r.refs == CntMax) hst = ST_SAT;
                 else begin upd.refs = rd_r.refs + 16'd1; mark = 1'b1; end
      OP_RELEASE: if (rd_r.refs == 16'd0) hst = ST_ZERO;
                 else begin
                   upd.refs = rd_r.refs - 16'd1;
                   if (upd.refs == 16'd0) begin
                     mark = 1'b1;
                     kill = !rd_r.keyed && rd_r.pins == 16'd0 && rd_r.infl == 16'd0;
                   end
                 end
      OP_PIN:    if (rd_r.pins == CntMax) hst = ST_SAT;
                 else begin upd.pins = rd_r.pins + 16'd1; mark = 1'b1; end
      OP_UNPIN:  if (rd_r.pins == 16'd0) hst = ST_ZERO;
                 else begin
                   upd.pins = rd_r.pins - 16'd1;
                   kill = !rd_r.keyed && rd_r.refs == 16'd0 && upd.pins == 16'd0 &&
                          rd_r.infl == 16'd0;
                 end
      OP_BEGIN:  if (rd_r.infl == CntMax) hst = ST_SAT;
                 else upd.infl = rd_r.infl + 16'd1;
      OP_END:    if (rd_r.infl == 16'd0) hst = ST_ZERO;
                 else begin
                   upd.infl = rd_r.infl - 16'd1;
                   kill = !rd_r.keyed && rd_r.refs == 16'd0 && rd_r.pins == 16'd0 &&
                          upd.infl == 16'd0;
                 end
      OP_TOUCH:  mark = 1'b1;
      default:   mark = 1'b0;
    endcase
    if (!hok) hst = ST_INVALID;
    ngen = rd_r.gen + 15'd1;
    if (ngen == 15'd0) ngen = 15'd1;
  end

  // Slot that is cleared back to its free state with a new generation.
  slot_t dead;
  always_comb begin
    dead = '0;
    dead.gen = ngen;
  end

  // Next generation of the eviction victim, skipping zero.
  logic [14:0] best_ngen;
  assign best_ngen = (best_gen_r == 15'h7fff) ? 15'd1 : best_gen_r + 15'd1;

  // Memory write selection.
  always_comb begin
    we = 1'b0;
    wa = hidx;
    wd = rd_r;
    if (cmd.clr_step) begin
      we = 1'b1;
      wa = clr_r[IW-1:0];
      wd = '0;
      wd.gen = 15'd1;
    end else if (cmd.exec && st.is_create) begin
      we = found_r;
      wa = tgt_r;
      wd = '0;
      wd.live  = 1'b1;
      wd.gen   = tgt_gen_r;
      wd.w     = w_r;
      wd.h     = h_r;
      wd.refs  = 16'd1;
      wd.keyed = key_r;
      wd.last  = serial_r + 32'd1;
    end else if (cmd.exec) begin
      we = hok && hst == ST_OK;
      wa = hidx;
      wd = kill ? dead : upd;
      if (!kill && mark) wd.last = serial_r + 32'd1;
    end else if (cmd.evict) begin
      we = best_v_r;
      wa = best_r;
      wd = '0;
      wd.gen = best_ngen;
    end
  end

  // Clearing pass and use serial.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r    <= '0;
      serial_r <= '0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + CW'(1);
      if (cmd.exec && st.is_create && found_r) serial_r <= serial_r + 32'd1;
      else if (cmd.exec && !st.is_create && hok && hst == ST_OK && mark)
        serial_r <= serial_r + 32'd1;
    end
  end

  // Scan counter; the read for entry cnt arrives in the cycle after.
  logic [33:0] bytes;
  assign bytes = {6'd0, 26'(rd_r.w) * 26'(rd_r.h), 2'b00};
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      cnt_r   <= '0;
      cnt_v_r <= 1'b0;
    end else if (cmd.scan_step) begin
      cnt_r     <= st.scan_last ? cnt_r : cnt_r + CW'(1);
      cnt_v_r   <= !st.scan_last;
      cnt_idx_r <= cnt_r[IW-1:0];
    end
  end

  // Free-slot search, warm sum and least recently used search.
  always_ff @(posedge clk) begin
    if (cmd.rd_handle) begin
      found_r  <= 1'b0;
      total_r  <= '0;
      ev_r     <= '0;
    end else if (cnt_v_r && (cmd.scan_step || cmd.scan_start) && st.is_create) begin
      if (!found_r && !rd_r.live) begin
        found_r   <= 1'b1;
        tgt_r     <= cnt_idx_r;
        tgt_gen_r <= rd_r.gen;
      end
    end else if (cnt_v_r && (cmd.sum_step || (cmd.scan_start && st.is_budget &&
                 !cmd.evict && ev_r == 7'd0 && !best_v_r && !cmd.min_step)) && warm) begin
      total_r <= total_r + bytes;
    end
    if (cmd.evict && best_v_r) begin
      total_r <= total_r - {6'd0, best_px_r, 2'b00};
      if (ev_r != 7'd127) ev_r <= ev_r + 7'd1;
    end
    if (cmd.scan_start) best_v_r <= 1'b0;
    if (cmd.evict && cnt_v_r && warm &&
        (!best_v_r || rd_r.last < best_last_r)) begin
      best_v_r    <= 1'b1;
      best_r      <= cnt_idx_r;
      best_gen_r  <= rd_r.gen;
      best_last_r <= rd_r.last;
      best_px_r   <= rd_r.w * rd_r.h;
    end else if (cmd.min_step && cnt_v_r && warm &&
        (!best_v_r || rd_r.last < best_last_r)) begin
      best_v_r    <= 1'b1;
      best_r      <= cnt_idx_r;
      best_gen_r  <= rd_r.gen;
      best_last_r <= rd_r.last;
      best_px_r   <= rd_r.w * rd_r.h;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status        <= ST_OK;
      out_handle        <= '0;
      out_width         <= '0;
      out_height        <= '0;
      out_ref_count     <= '0;
      out_freed         <= 1'b0;
      out_evicted_count <= '0;
      out_warm_bytes    <= '0;
      if (op_r > OP_BUDGET) begin
        out_status <= ST_INVALID;
      end else if (st.is_budget) begin
        out_evicted_count <= ev_r;
        out_warm_bytes    <= total_r[33] ? 33'h1_ffff_ffff : total_r[32:0];
      end else if (st.is_create) begin
        if (size_bad) out_status <= ST_SIZE;
        else if (!found_r) out_status <= ST_FULL;
        else begin
          out_handle    <= {tgt_gen_r, 16'(tgt_r) + 16'd1};
          out_width     <= w_r;
          out_height    <= h_r;
          out_ref_count <= 16'd1;
        end
      end else begin
        out_handle <= hdl_r[30:0];
        if (!idx_ok || !hok) out_status <= ST_INVALID;
        else begin
          out_status    <= hst;
          out_freed     <= hst == ST_OK && kill;
          out_ref_count <= (hst == ST_OK) ? (kill ? 16'd0 : upd.refs) : rd_r.refs;
          if (op_r == OP_LOOKUP) begin
            out_width  <= rd_r.w;
            out_height <= rd_r.h;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for generational_handle_table: a driver feeds handle-table
// commands from a queue, a monitor checks each result word against a built-in predictor.
// Depends on ght_pkg and the generational_handle_table RTL.
`timescale 1ns / 1ps
module testbench;
  import ght_pkg::*;

  localparam int NumSlots = 64;
  localparam int MaxSide = 4096;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] handle;
    logic [12:0] width;
    logic [12:0] height;
    logic        keyed;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] handle;
    logic [12:0] width;
    logic [12:0] height;
    logic [15:0] refs;
    logic        freed;
    logic [6:0]  evicted;
    logic [32:0] warm;
  } res_word_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [3:0] in_op;
  logic [31:0] in_handle;
  logic [12:0] in_width;
  logic [12:0] in_height;
  logic in_keyed;
  logic cfg_we;
  logic [32:0] cfg_wdata;
  logic out_valid;
  logic [2:0] out_status;
  logic [30:0] out_handle;
  logic [12:0] out_width;
  logic [12:0] out_height;
  logic [15:0] out_ref_count;
  logic out_freed;
  logic [6:0] out_evicted_count;
  logic [32:0] out_warm_bytes;

  // Predictor copy of the slot table.
  logic        tbl_live [NumSlots];
  logic [14:0] tbl_gen [NumSlots];
  logic [12:0] tbl_w [NumSlots];
  logic [12:0] tbl_h [NumSlots];
  logic [15:0] tbl_refs [NumSlots];
  logic [15:0] tbl_pins [NumSlots];
  logic [15:0] tbl_infl [NumSlots];
  logic        tbl_keyed [NumSlots];
  logic [31:0] tbl_last [NumSlots];
  logic [31:0] serial_ctr;
  logic [32:0] budget_bytes;

  cmd_word_t cmd_queue[$];
  res_word_t expected_results[$];
  int send_idle_pct;
  int mismatch_cnt;
  int cmds_sent;
  int results_seen;
  int evictions_seen;
  int watch_cnt;
  int status_hist [8];

  generational_handle_table i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_handle(in_handle), .in_width(in_width), .in_height(in_height),
    .in_keyed(in_keyed), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_status(out_status), .out_handle(out_handle),
    .out_width(out_width), .out_height(out_height), .out_ref_count(out_ref_count),
    .out_freed(out_freed), .out_evicted_count(out_evicted_count),
    .out_warm_bytes(out_warm_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] handle_of(int s);
    return {1'b0, tbl_gen[s], 16'(s + 1)};
  endfunction

  function automatic logic slot_warm(int s);
    return tbl_live[s] && tbl_keyed[s] && tbl_refs[s] == 0 && tbl_pins[s] == 0 &&
           tbl_infl[s] == 0;
  endfunction

  function automatic logic slot_idle_anon(int s);
    return !tbl_keyed[s] && tbl_refs[s] == 0 && tbl_pins[s] == 0 && tbl_infl[s] == 0;
  endfunction

  function automatic void stamp_use(int s);
    serial_ctr = serial_ctr + 32'd1;
    tbl_last[s] = serial_ctr;
  endfunction

  // Destroying a slot bumps its generation, skipping zero.
  function automatic void drop_slot(int s);
    tbl_live[s] = 1'b0;
    tbl_w[s] = '0;
    tbl_h[s] = '0;
    tbl_refs[s] = '0;
    tbl_pins[s] = '0;
    tbl_infl[s] = '0;
    tbl_keyed[s] = 1'b0;
    tbl_last[s] = '0;
    tbl_gen[s] = tbl_gen[s] + 15'd1;
    if (tbl_gen[s] == '0) tbl_gen[s] = 15'd1;
  endfunction

  function automatic logic [39:0] slot_size_bytes(int s);
    return 40'(tbl_w[s]) * 40'(tbl_h[s]) * 40'd4;
  endfunction

  // Applies one command to the table copy and returns the result word it must give.
  function automatic res_word_t table_step(cmd_word_t c);
    res_word_t r;
    int s;
    int best;
    logic [39:0] total;
    logic [14:0] hgen;
    logic [15:0] henc;
    r = '0;
    hgen = c.handle[30:16];
    henc = c.handle[15:0];
    if (c.op == OP_CREATE) begin
      if (c.width == 0 || c.height == 0 || c.width > MaxSide || c.height > MaxSide) begin
        r.status = ST_SIZE;
      end else begin
        s = 0;
        while (s < NumSlots && tbl_live[s]) s++;
        if (s >= NumSlots) begin
          r.status = ST_FULL;
        end else begin
          tbl_live[s] = 1'b1;
          tbl_w[s] = c.width;
          tbl_h[s] = c.height;
          tbl_refs[s] = 16'd1;
          tbl_pins[s] = '0;
          tbl_infl[s] = '0;
          tbl_keyed[s] = c.keyed;
          stamp_use(s);
          r.handle = {tbl_gen[s], 16'(s + 1)};
          r.width = c.width;
          r.height = c.height;
          r.refs = 16'd1;
        end
      end
    end else if (c.op == OP_BUDGET) begin
      total = '0;
      for (int i = 0; i < NumSlots; i++) if (slot_warm(i)) total += slot_size_bytes(i);
      while (total > 40'(budget_bytes)) begin
        best = -1;
        for (int i = 0; i < NumSlots; i++)
          if (slot_warm(i) && (best < 0 || tbl_last[i] < tbl_last[best])) best = i;
        if (best < 0) break;
        total -= slot_size_bytes(best);
        drop_slot(best);
        if (r.evicted != 7'h7f) r.evicted++;
      end
      r.warm = (total > 40'h1_ffff_ffff) ? 33'h1_ffff_ffff : total[32:0];
    end else if (c.op > OP_BUDGET) begin
      r.status = ST_INVALID;
    end else begin
      r.handle = c.handle[30:0];
      s = int'(henc) - 1;
      if (c.handle[31] || henc == 0 || henc > NumSlots || !tbl_live[s] || tbl_gen[s] != hgen)
      begin
        r.status = ST_INVALID;
      end else begin
        case (op_t'(c.op))
          OP_RETAIN: begin
            if (tbl_refs[s] == CntMax) r.status = ST_SAT;
            else begin
              tbl_refs[s]++;
              stamp_use(s);
            end
          end
          OP_RELEASE: begin
            if (tbl_refs[s] == 0) r.status = ST_ZERO;
            else begin
              tbl_refs[s]--;
              // Only the release that drops the last reference marks the slot used.
              if (tbl_refs[s] == 0) begin
                stamp_use(s);
                if (slot_idle_anon(s)) begin
                  drop_slot(s);
                  r.freed = 1'b1;
                end
              end
            end
          end
          OP_PIN: begin
            if (tbl_pins[s] == CntMax) r.status = ST_SAT;
            else begin
              tbl_pins[s]++;
              stamp_use(s);
            end
          end
          OP_UNPIN: begin
            if (tbl_pins[s] == 0) r.status = ST_ZERO;
            else begin
              tbl_pins[s]--;
              if (slot_idle_anon(s)) begin
                drop_slot(s);
                r.freed = 1'b1;
              end
            end
          end
          OP_BEGIN: begin
            if (tbl_infl[s] == CntMax) r.status = ST_SAT;
            else tbl_infl[s]++;
          end
          OP_END: begin
            if (tbl_infl[s] == 0) r.status = ST_ZERO;
            else begin
              tbl_infl[s]--;
              if (slot_idle_anon(s)) begin
                drop_slot(s);
                r.freed = 1'b1;
              end
            end
          end
          OP_TOUCH: stamp_use(s);
          default: begin
            r.width = tbl_w[s];
            r.height = tbl_h[s];
          end
        endcase
        r.refs = tbl_refs[s];
      end
    end
    return r;
  endfunction

  // Driver: a command is taken at an edge with start high and busy low.
  always @(posedge clk) begin
    cmd_word_t nxt;
    logic fire;
    if (!rst_n) begin
      start <= 1'b0;
      in_op <= '0;
      in_handle <= '0;
      in_width <= '0;
      in_height <= '0;
      in_keyed <= 1'b0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        expected_results = {expected_results,
                            table_step({in_op, in_handle, in_width, in_height, in_keyed})};
        cmds_sent++;
      end
      if (!start || fire) begin
        if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = cmd_queue.pop_front();
          start <= 1'b1;
          in_op <= nxt.op;
          in_handle <= nxt.handle;
          in_width <= nxt.width;
          in_height <= nxt.height;
          in_keyed <= nxt.keyed;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string field, logic [39:0] got, logic [39:0] want);
    $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h", $realtime, results_seen,
             field, got, want);
    mismatch_cnt++;
  endtask

  // Monitor: every strobed result word is checked against the oldest expectation.
  always @(posedge clk) begin
    res_word_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", 40'(out_status), '0);
      end else begin
        want = expected_results.pop_front();
        if (out_status != want.status)
          report_mismatch("status", 40'(out_status), 40'(want.status));
        if (out_handle != want.handle)
          report_mismatch("handle", 40'(out_handle), 40'(want.handle));
        if (out_width != want.width)
          report_mismatch("width", 40'(out_width), 40'(want.width));
        if (out_height != want.height)
          report_mismatch("height", 40'(out_height), 40'(want.height));
        if (out_ref_count != want.refs)
          report_mismatch("ref_count", 40'(out_ref_count), 40'(want.refs));
        if (out_freed != want.freed)
          report_mismatch("freed", 40'(out_freed), 40'(want.freed));
        if (out_evicted_count != want.evicted)
          report_mismatch("evicted_count", 40'(out_evicted_count), 40'(want.evicted));
        if (out_warm_bytes != want.warm)
          report_mismatch("warm_bytes", 40'(out_warm_bytes), 40'(want.warm));
        status_hist[want.status]++;
        evictions_seen += int'(want.evicted);
      end
      results_seen++;
    end
  end

  // Watchdog: too long without any word moving ends the run.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) watch_cnt <= 0;
    else watch_cnt <= watch_cnt + 1;
    if (watch_cnt >= WatchLimit) begin
      $display("watchdog expired with %0d results outstanding", expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(cmd_word_t c);
    while (cmd_queue.size() >= 2) @(posedge clk);
    cmd_queue = {cmd_queue, c};
  endtask

  // Waits until every queued command is answered and the block is quiet.
  task automatic settle();
    while (cmd_queue.size() > 0 || start || expected_results.size() > 0 || busy)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_budget(logic [32:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    budget_bytes = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic cmd_word_t mk(op_t op, logic [31:0] h);
    cmd_word_t c;
    c = '0;
    c.op = op;
    c.handle = h;
    return c;
  endfunction

  function automatic cmd_word_t mk_create(int w, int h, logic k);
    cmd_word_t c;
    c = mk(OP_CREATE, $urandom());
    c.width = 13'(w);
    c.height = 13'(h);
    c.keyed = k;
    return c;
  endfunction

  // Picks a handle, mostly of a live slot, sometimes stale or garbage.
  function automatic logic [31:0] pick_handle();
    int s;
    if ($urandom_range(99) < 6) return $urandom();
    for (int tries = 0; tries < 8; tries++) begin
      s = $urandom_range(NumSlots - 1);
      if (tbl_live[s]) break;
    end
    if ($urandom_range(99) < 3) return {1'b1, tbl_gen[s], 16'(s + 1)};
    return handle_of(s);
  endfunction

  function automatic cmd_word_t random_cmd();
    int r;
    int side;
    cmd_word_t c;
    r = $urandom_range(99);
    if (r < 22) begin
      side = ($urandom_range(9) == 0) ? MaxSide : 64;
      c = mk_create($urandom_range(1, side), $urandom_range(1, side),
                    1'($urandom_range(1)));
      if ($urandom_range(30) == 0) begin
        c.width = 13'($urandom());
        c.height = 13'($urandom());
      end
    end else if (r < 92) begin
      c = mk(op_t'($urandom_range(OP_RETAIN, OP_LOOKUP)), pick_handle());
      c.width = 13'($urandom());
      c.height = 13'($urandom());
      c.keyed = 1'($urandom_range(1));
    end else if (r < 98) begin
      c = mk(OP_BUDGET, $urandom());
    end else begin
      c = mk(OP_CREATE, $urandom());
      c.op = 4'($urandom_range(10, 15));
    end
    return c;
  endfunction

  initial begin
    logic [32:0] budgets [4];
    logic [31:0] hs;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_idle_pct = 0;
    mismatch_cnt = 0;
    cmds_sent = 0;
    results_seen = 0;
    evictions_seen = 0;
    serial_ctr = '0;
    budget_bytes = BudgetReset;
    for (int i = 0; i < NumSlots; i++) begin
      tbl_live[i] = 1'b0;
      tbl_gen[i] = 15'd1;
      tbl_w[i] = '0;
      tbl_h[i] = '0;
      tbl_refs[i] = '0;
      tbl_pins[i] = '0;
      tbl_infl[i] = '0;
      tbl_keyed[i] = 1'b0;
      tbl_last[i] = '0;
    end
    for (int i = 0; i < 8; i++) status_hist[i] = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: size limits, every operation, bad handles and unknown codes.
    send(mk_create(0, 5, 1'b0));
    send(mk_create(4097, 1, 1'b0));
    send(mk_create(1, 8191, 1'b0));
    send(mk_create(4096, 4096, 1'b1));
    send(mk_create(1, 1, 1'b0));
    settle();
    hs = handle_of(1);
    send(mk(OP_LOOKUP, handle_of(0)));
    send(mk(OP_PIN, hs));
    send(mk(OP_BEGIN, hs));
    send(mk(OP_RETAIN, hs));
    send(mk(OP_TOUCH, hs));
    send(mk(OP_RELEASE, hs));
    send(mk(OP_RELEASE, hs));
    send(mk(OP_RELEASE, hs));
    send(mk(OP_UNPIN, hs));
    send(mk(OP_UNPIN, hs));
    send(mk(OP_END, hs));
    send(mk(OP_LOOKUP, hs));
    send(mk(OP_LOOKUP, hs | 32'h8000_0000));
    send(mk(OP_LOOKUP, 32'h0001_0000));
    send(mk(OP_LOOKUP, 32'h0001_0041));
    send(mk(OP_LOOKUP, 32'hffff_ffff));
    send(mk(OP_BUDGET, '0));
    for (int i = 10; i < 16; i++) begin
      hs = $urandom();
      send(mk(op_t'(OP_CREATE), hs));
      cmd_queue[cmd_queue.size() - 1].op = 4'(i);
    end
    // Fill the table, then ask once more.
    for (int i = 0; i < NumSlots; i++)
      send(mk_create($urandom_range(1, 64), $urandom_range(1, 64), 1'($urandom_range(1))));
    send(mk_create(3, 3, 1'b0));
    write_budget('0);
    send(mk(OP_BUDGET, '0));

    // Random phases under different sender pacing and warm budgets.
    budgets[0] = 33'h1_0000_0000;
    budgets[1] = BudgetReset;
    budgets[2] = 33'd20000;
    budgets[3] = 33'd0;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 67 : 0;
      for (int n = 0; n < 600; n++) begin
        if (n % 160 == 0) write_budget((n % 320 == 0) ? budgets[(ph + n / 160) % 4]
                                                     : 33'($urandom_range(0, 400000)));
        send(random_cmd());
      end
    end
    settle();

    $display("Sent %0d commands, checked %0d results, %0d warm evictions.",
             cmds_sent, results_seen, evictions_seen);
    $display("Status mix: ok %0d, invalid %0d, zero %0d, full %0d, saturated %0d, size %0d.",
             status_hist[ST_OK], status_hist[ST_INVALID], status_hist[ST_ZERO],
             status_hist[ST_FULL], status_hist[ST_SAT], status_hist[ST_SIZE]);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ght_pkg.sv
rtl/ght_ctrl.sv
rtl/ght_datapath.sv
rtl/generational_handle_table.sv
test/testbench.sv
